@@ hw/rtl/fpe_pkg.sv @@
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared constants, command codes and controller/datapath types for the
// frustum plane extraction block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpe_pkg;

  // fixed-point format of all matrix elements and coefficients
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int PLANE_COUNT = 6;

  // request command codes
  localparam logic [1:0] CMD_LOAD_PROJ = 2'd0;
  localparam logic [1:0] CMD_LOAD_VIEW = 2'd1;
  localparam logic [1:0] CMD_EXTRACT   = 2'd2;

  localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

  // controller to datapath commands
  typedef struct packed {
    logic       load_proj;
    logic       load_view;
    logic       clip_mul;
    logic       clip_acc;
    logic       planes_load;
    logic       plane_shift;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_start;
    logic       div_start;
    logic       div_store;
    logic [1:0] col;
    logic [1:0] row;
    logic [1:0] kidx;
  } fpe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sqrt_done;
    logic len_zero;
    logic div_done;
  } fpe_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpe_ram.sv @@
// ----------------------------------------------------------------------------
// fpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/fpe_sqrt.sv @@
// ----------------------------------------------------------------------------
// fpe_sqrt
// Bit-pair iterative integer square root of a 64-bit unsigned value,
// one result bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] n_q, n_d;
  logic [63:0] root_q, root_d;
  logic [63:0] bit_q, bit_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] trial;

  // one step of the digit recurrence
  always_comb begin
    trial  = root_q + bit_q;
    n_d    = n_q;
    root_d = root_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = radicand_i;
      root_d = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d    = n_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[31:0];

endmodule

`default_nettype wire

@@ hw/rtl/fpe_div.sv @@
// ----------------------------------------------------------------------------
// fpe_div
// Restoring unsigned divider, one quotient bit per cycle, for the scaled
// coefficient magnitude over the 32-bit normal length.
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [fpe_pkg::DATA_W+fpe_pkg::FRAC_BITS:0] dividend_i,
  input  wire logic [31:0]                       divisor_i,
  output logic                                   done_o,
  output logic [fpe_pkg::DATA_W+fpe_pkg::FRAC_BITS:0] quotient_o
);

  import fpe_pkg::*;

  localparam int DIV_W = DATA_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             ge;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : trial[31:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/fpe_dp.sv @@
// ----------------------------------------------------------------------------
// fpe_dp
// Datapath: matrix stores, shared multiplier, clip accumulator, plane
// registers, square root and divider units and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fpe_pkg::fpe_cmd_t   cmd_i,
  input  wire logic [1:0]          column_i,
  input  wire logic signed [31:0]  elem_row0_i,
  input  wire logic signed [31:0]  elem_row1_i,
  input  wire logic signed [31:0]  elem_row2_i,
  input  wire logic signed [31:0]  elem_row3_i,
  output fpe_pkg::fpe_status_t     status_o,
  output logic signed [31:0]       coef_a_o,
  output logic signed [31:0]       coef_b_o,
  output logic signed [31:0]       coef_c_o,
  output logic signed [31:0]       coef_d_o,
  output logic                     degenerate_o
);

  import fpe_pkg::*;

  localparam int TERM_W = 64 - FRAC_BITS;
  localparam int ACC_W  = TERM_W + 2;
  localparam int DIV_W  = DATA_W + FRAC_BITS + 1;

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] x);
    if ((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31])) begin
      return x[31:0];
    end
    return x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x[32] == x[31]) begin
      return x[31:0];
    end
    return x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  logic [127:0]             p_rdata, v_rdata;
  logic [127:0]             wdata;
  logic signed [31:0]       p_elem, v_elem, cur_coef;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       product_q;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_q, acc_sum;
  logic signed [31:0]       clip_q [16];
  logic signed [31:0]       plane_q [PLANE_COUNT][4];
  logic signed [31:0]       plane_d [PLANE_COUNT][4];
  logic [63:0]              sumsq_q;
  logic [31:0]              len_q;
  logic                     deg_q;
  logic signed [31:0]       out_q [4];
  logic                     sqrt_done;
  logic [31:0]              root;
  logic                     div_done;
  logic [DIV_W-1:0]         quotient;
  logic [32:0]              coef_ext, mag;
  logic [DIV_W-1:0]         dividend;
  logic                     q_big;
  logic signed [31:0]       q_res;

  // matrix stores, one column word per entry
  assign wdata = {elem_row3_i, elem_row2_i, elem_row1_i, elem_row0_i};

  fpe_ram #(.WIDTH(128), .DEPTH(4)) u_proj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_proj),
    .waddr_i (column_i),
    .wdata_i (wdata),
    .raddr_i (cmd_i.kidx),
    .rdata_o (p_rdata)
  );

  fpe_ram #(.WIDTH(128), .DEPTH(4)) u_view_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_view),
    .waddr_i (column_i),
    .wdata_i (wdata),
    .raddr_i (cmd_i.col),
    .rdata_o (v_rdata)
  );

  // operand selection for the shared multiplier
  assign p_elem   = p_rdata[{cmd_i.row, 5'b0} +: 32];
  assign v_elem   = v_rdata[{cmd_i.kidx, 5'b0} +: 32];
  assign cur_coef = plane_q[0][cmd_i.kidx];
  assign mul_a    = cmd_i.sq_mul ? cur_coef : p_elem;
  assign mul_b    = cmd_i.sq_mul ? cur_coef : v_elem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip_mul || cmd_i.sq_mul) begin
      product_q <= mul_a * mul_b;
    end
  end

  // clip accumulation, floor shift of each product
  assign term    = product_q[63:FRAC_BITS];
  assign acc_sum = ((cmd_i.kidx == 2'd0) ? ACC_W'(0) : acc_q) + ACC_W'(term);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip_acc) begin
      acc_q <= acc_sum;
      if (cmd_i.kidx == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          clip_q[i] <= clip_q[i+1];
        end
        clip_q[15] <= sat_acc(acc_sum);
      end
    end
  end

  // six planes from the clip matrix: row3 minus or plus row0..row2
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int k = 0; k < 4; k++) begin
        if (p == 0 || p == 3 || p == 4) begin
          plane_d[p][k] = sat33(33'(clip_q[k*4+3]) - 33'(clip_q[k*4+(p/2)]));
        end else begin
          plane_d[p][k] = sat33(33'(clip_q[k*4+3]) + 33'(clip_q[k*4+(p/2)]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.planes_load) begin
      plane_q <= plane_d;
    end else if (cmd_i.plane_shift) begin
      for (int p = 0; p < PLANE_COUNT - 1; p++) begin
        plane_q[p] <= plane_q[p+1];
      end
    end
  end

  // sum of squares of the normal
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_acc) begin
      sumsq_q <= ((cmd_i.kidx == 2'd0) ? 64'd0 : sumsq_q) + 64'(product_q);
    end
  end

  fpe_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (sumsq_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // signed coefficient magnitude scaled by one
  assign coef_ext = 33'(cur_coef);
  assign mag      = cur_coef[31] ? (33'd0 - coef_ext) : coef_ext;
  assign dividend = {mag, FRAC_BITS'(0)};

  fpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sign and saturate the quotient
  always_comb begin
    if (cur_coef[31]) begin
      q_big = (|quotient[DIV_W-1:32]) || (quotient[31] && (|quotient[30:0]));
      q_res = q_big ? 32'sh8000_0000 : (32'sd0 - quotient[31:0]);
    end else begin
      q_big = |quotient[DIV_W-1:31];
      q_res = q_big ? 32'sh7fff_ffff : quotient[31:0];
    end
  end

  // normal length and result registers
  always_ff @(posedge clk_i) begin
    if (sqrt_done) begin
      len_q <= root;
      deg_q <= (root == 32'd0);
      for (int k = 0; k < 4; k++) begin
        out_q[k] <= '0;
      end
    end else if (cmd_i.div_store) begin
      out_q[cmd_i.kidx] <= q_res;
    end
  end

  assign status_o.sqrt_done = sqrt_done;
  assign status_o.len_zero  = (root == 32'd0);
  assign status_o.div_done  = div_done;

  assign coef_a_o     = out_q[0];
  assign coef_b_o     = out_q[1];
  assign coef_c_o     = out_q[2];
  assign coef_d_o     = out_q[3];
  assign degenerate_o = deg_q;

endmodule

`default_nettype wire

@@ hw/rtl/fpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpe_ctrl
// Controller: sequences loads, the clip product, and per plane the sum of
// squares, square root, four divisions (none for a zero length) and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fpe_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            command_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [2:0]                 plane_index_o,
  output logic                       last_plane_o,
  output fpe_pkg::fpe_cmd_t          cmd_o,
  input  wire fpe_pkg::fpe_status_t  status_i
);

  import fpe_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD      = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_ACC     = 4'd3;
  localparam logic [3:0] S_PLN     = 4'd4;
  localparam logic [3:0] S_SQ      = 4'd5;
  localparam logic [3:0] S_SQA     = 4'd6;
  localparam logic [3:0] S_SQRT_GO = 4'd7;
  localparam logic [3:0] S_SQRT_W  = 4'd8;
  localparam logic [3:0] S_DIV_GO  = 4'd9;
  localparam logic [3:0] S_DIV_W   = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] c_q, c_d, r_q, r_d, k_q, k_d;
  logic [2:0] plane_q, plane_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    r_d     = r_q;
    k_d     = k_q;
    plane_d = plane_q;
    cmd_o   = '0;
    cmd_o.col  = c_q;
    cmd_o.row  = r_q;
    cmd_o.kidx = k_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_proj = accept && (command_i == CMD_LOAD_PROJ);
        cmd_o.load_view = accept && (command_i == CMD_LOAD_VIEW);
        if (accept && (command_i == CMD_EXTRACT)) begin
          c_d     = '0;
          r_d     = '0;
          k_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.clip_mul = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.clip_acc = 1'b1;
        k_d            = k_q + 2'd1;
        state_d        = S_RD;
        if (k_q == 2'd3) begin
          r_d = r_q + 2'd1;
          if (r_q == 2'd3) begin
            c_d = c_q + 2'd1;
            if (c_q == 2'd3) begin
              state_d = S_PLN;
            end
          end
        end
      end
      S_PLN: begin
        cmd_o.planes_load = 1'b1;
        plane_d           = '0;
        k_d               = '0;
        state_d           = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_SQA;
      end
      S_SQA: begin
        cmd_o.sq_acc = 1'b1;
        if (k_q == 2'd2) begin
          k_d     = '0;
          state_d = S_SQRT_GO;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_SQ;
        end
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (status_i.sqrt_done) begin
          state_d = status_i.len_zero ? S_OUT : S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_W;
      end
      S_DIV_W: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          k_d             = k_q + 2'd1;
          state_d         = (k_q == 2'd3) ? S_OUT : S_DIV_GO;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (plane_q == LAST_PLANE) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.plane_shift = 1'b1;
            plane_d           = plane_q + 3'd1;
            k_d               = '0;
            state_d           = S_SQ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      c_q     <= '0;
      r_q     <= '0;
      k_q     <= '0;
      plane_q <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      r_q     <= r_d;
      k_q     <= k_d;
      plane_q <= plane_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign plane_index_o = plane_q;
  assign last_plane_o  = (plane_q == LAST_PLANE);

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result offered while a request is accepted");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plane_q <= LAST_PLANE)
    else $error("plane counter out of range");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.sqrt_done |-> (state_q == S_SQRT_W))
    else $error("square root finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIV_W))
    else $error("division finished outside its wait state");

  a_extract_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_EXTRACT) |=> (state_q == S_RD))
    else $error("extract request did not start the clip product");

endmodule

`default_nettype wire

@@ hw/rtl/frustum_plane_extraction.sv @@
// ----------------------------------------------------------------------------
// frustum_plane_extraction
// Loads projection and view matrices by column, forms their product and
// emits the six normalized frustum planes in signed fixed point.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o  command, column, elem_row0..3
// out      out  out_valid_o/out_ready_i plane_index, coef_a..d, degenerate,
//                                      last_plane
//
// A load request writes one matrix column. An extract request forms the
// clip product (16 elements, four multiply-accumulates each on the one
// shared multiplier), then per plane the squares and the 32-step square
// root and four 49-step divisions (none for a zero length). Requests are
// taken only while idle; the block waits on each plane until it is taken.
// Reset clears the control state; matrix stores hold nothing valid until
// loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_plane_extraction (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [1:0]         column_i,
  input  wire logic signed [31:0] elem_row0_i,
  input  wire logic signed [31:0] elem_row1_i,
  input  wire logic signed [31:0] elem_row2_i,
  input  wire logic signed [31:0] elem_row3_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              plane_index_o,
  output logic signed [31:0]      coef_a_o,
  output logic signed [31:0]      coef_b_o,
  output logic signed [31:0]      coef_c_o,
  output logic signed [31:0]      coef_d_o,
  output logic                    degenerate_o,
  output logic                    last_plane_o
);

  import fpe_pkg::*;

  fpe_cmd_t    cmd;
  fpe_status_t status;

  // sequencer
  fpe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .plane_index_o (plane_index_o),
    .last_plane_o  (last_plane_o),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  // arithmetic and storage
  fpe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .column_i     (column_i),
    .elem_row0_i  (elem_row0_i),
    .elem_row1_i  (elem_row1_i),
    .elem_row2_i  (elem_row2_i),
    .elem_row3_i  (elem_row3_i),
    .status_o     (status),
    .coef_a_o     (coef_a_o),
    .coef_b_o     (coef_b_o),
    .coef_c_o     (coef_c_o),
    .coef_d_o     (coef_d_o),
    .degenerate_o (degenerate_o)
  );

endmodule

`default_nettype wire
